// ===== sv/bdqs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdqs_pkg
// Shared types and codes for the bounded deque with membership search.
// ----------------------------------------------------------------------------
package bdqs_pkg;

  localparam int VALUE_W  = 32;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // command codes on the input channel
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd5;

  // result status codes
  localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STS_FULL  = 2'd2;

  // decoded operation, unknown codes become a no-op
  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_CLEAR,
    OP_SEARCH,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [VALUE_W-1:0] value;
  } qitem_t;

  // status sits in the lowest bits when packed onto the bus
  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic                found;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

// ===== sv/bdqs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdqs_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module bdqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/bdqs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdqs_front
// Accepts requests, decodes the command and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module bdqs_front
  import bdqs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [VALUE_W-1:0] in_tdata,
  input  logic [CMD_W-1:0]   in_tuser,
  output logic               q_vld,
  output qitem_t             q_item,
  input  logic               q_pop
);

  qitem_t      slot_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  fill_r, fill_nxt;
  logic        push, pop;
  op_t         op_dec;

  always_comb begin
    unique case (in_tuser)
      CMD_PUSH_FRONT: op_dec = OP_PUSH_FRONT;
      CMD_PUSH_BACK:  op_dec = OP_PUSH_BACK;
      CMD_POP_FRONT:  op_dec = OP_POP_FRONT;
      CMD_POP_BACK:   op_dec = OP_POP_BACK;
      CMD_CLEAR:      op_dec = OP_CLEAR;
      CMD_SEARCH:     op_dec = OP_SEARCH;
      default:        op_dec = OP_NOP;
    endcase
  end

  assign in_tready = (fill_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_vld     = (fill_r != 2'd0);
  assign pop       = q_pop && q_vld;
  assign q_item    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= '{op: op_dec, value: in_tdata};
    end
  end

endmodule

// ===== sv/bdqs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdqs_back
// Executes queued requests on the ring store and scans it for searches.
// ----------------------------------------------------------------------------
module bdqs_back
  import bdqs_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_vld,
  input  qitem_t  q_item,
  output logic    q_pop,
  output logic    out_vld,
  output result_t out_res,
  input  logic    out_rdy
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [AW-1:0]      front_r, front_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic               hit_r, hit_nxt;
  logic [VALUE_W-1:0] key_r, key_nxt;
  logic               out_vld_r, out_vld_nxt;
  result_t            res_r, res_nxt;

  logic               can_emit, emit, match, full, empty;
  logic [STATUS_W-1:0] sts;
  logic               fnd;
  logic               we, re;
  logic [AW-1:0]      waddr, raddr;
  logic [VALUE_W-1:0] rdata;

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] pos,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(pos) + SW'(off);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  bdqs_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(q_item.value),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign can_emit = !out_vld_r || out_rdy;
  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign match    = cmp_vld_r && (rdata == key_r);
  assign raddr    = ring_add(front_r, idx_r);

  always_comb begin
    state_nxt   = state_r;
    front_nxt   = front_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    cmp_vld_nxt = 1'b0;
    hit_nxt     = hit_r;
    key_nxt     = key_r;
    q_pop       = 1'b0;
    we          = 1'b0;
    waddr       = ring_add(front_r, cnt_r);
    re          = 1'b0;
    emit        = 1'b0;
    sts         = STS_OK;
    fnd         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (q_vld && can_emit) begin
          q_pop = 1'b1;
          emit  = 1'b1;
          unique case (q_item.op)
            OP_PUSH_FRONT: begin
              if (full) begin
                sts = STS_FULL;
              end else begin
                front_nxt = (front_r == '0) ? AW'(DEPTH - 1) : front_r - 1'b1;
                waddr     = front_nxt;
                we        = 1'b1;
                cnt_nxt   = cnt_r + 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              if (full) begin
                sts = STS_FULL;
              end else begin
                we      = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (empty) begin
                sts = STS_EMPTY;
              end else begin
                front_nxt = ring_add(front_r, CW'(1));
                cnt_nxt   = cnt_r - 1'b1;
              end
            end
            OP_POP_BACK: begin
              if (empty) begin
                sts = STS_EMPTY;
              end else begin
                cnt_nxt = cnt_r - 1'b1;
              end
            end
            OP_CLEAR: begin
              if (empty) begin
                sts = STS_EMPTY;
              end else begin
                cnt_nxt   = '0;
                front_nxt = '0;
              end
            end
            OP_SEARCH: begin
              if (empty) begin
                sts = STS_EMPTY;
              end else begin
                // result goes out once the scan ends
                emit      = 1'b0;
                key_nxt   = q_item.value;
                idx_nxt   = '0;
                state_nxt = ST_SEARCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SEARCH: begin
        // one read issued per cycle, compare lags by the ram read register
        re          = (idx_r < cnt_r) && !match;
        cmp_vld_nxt = re;
        if (re) begin
          idx_nxt = idx_r + 1'b1;
        end
        if (cmp_vld_r && (match || idx_r == cnt_r)) begin
          hit_nxt   = match;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (can_emit) begin
          emit      = 1'b1;
          fnd       = hit_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_vld_nxt = emit || (out_vld_r && !out_rdy);
    res_nxt     = res_r;
    if (emit) begin
      res_nxt = '{count: COUNT_W'(cnt_nxt), found: fnd, status: sts};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      front_r   <= '0;
      cnt_r     <= '0;
      idx_r     <= '0;
      cmp_vld_r <= 1'b0;
      hit_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      front_r   <= front_nxt;
      cnt_r     <= cnt_nxt;
      idx_r     <= idx_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      hit_r     <= hit_nxt;
      out_vld_r <= out_vld_nxt;
    end
    key_r <= key_nxt;
    res_r <= res_nxt;
  end

  assign out_vld = out_vld_r;
  assign out_res = res_r;

endmodule

// ===== sv/bounded_deque_with_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// Ring-buffer deque of signed 32-bit values with push/pop at both ends,
// clear and a membership search; one result per request.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata                                 | tuser
//  ---------+-----------+---------------------------------------+------------
//  in_      | request   | [31:0] value                          | [2:0] command
//  out_     | result    | [1:0] status, [2] found, [7:3] count  | -
//
//  a request is seen in the two-entry queue in the cycle after acceptance; the engine
//  behind it takes a push, pop, clear or no-op request and registers its result in the same cycle.
//  a search reads the store through its single read port, one entry a cycle, ending early on a match.
//  rst_n clears the count and front position; the store itself is not cleared.
//  a stalled result register holds the engine; the queue takes two more requests.
// ----------------------------------------------------------------------------
module bounded_deque_with_search
  import bdqs_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [VALUE_W-1:0]        in_tdata,   // [31:0] value
  input  logic [CMD_W-1:0]          in_tuser,   // [2:0] command
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [$bits(result_t)-1:0] out_tdata  // [1:0] status, [2] found, [7:3] count
);

  logic    q_vld, q_pop;
  qitem_t  q_item;
  result_t res;

  bdqs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .q_vld    (q_vld),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  bdqs_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_vld  (q_vld),
    .q_item (q_item),
    .q_pop  (q_pop),
    .out_vld(out_tvalid),
    .out_res(res),
    .out_rdy(out_tready)
  );

  assign out_tdata = res;

endmodule

// ===== bench/bounded_deque_with_search_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_search_tb
// Drives push, pop, clear, search and unused command requests into the deque
// under random flow control and checks every result against a local copy of
// the ring store.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_tb;
  import bdqs_pkg::*;

  localparam int DEPTH      = 16;
  localparam int LONG_HOLD  = 300;
  localparam int PHASE_REQS = 300;

  // codes the block must ignore
  localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] value;
  } deque_req_t;

  logic                       clk        = 1'b0;
  logic                       rst_n      = 1'b0;
  logic                       in_tvalid  = 1'b0;
  logic                       in_tready;
  logic [VALUE_W-1:0]         in_tdata   = '0;
  logic [CMD_W-1:0]           in_tuser   = '0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [$bits(result_t)-1:0] out_tdata;

  deque_req_t request_queue[$];
  result_t    expected_results[$];
  int         mismatch_count = 0;
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  logic       in_fire        = 1'b0;
  logic       hold_off       = 1'b0;
  logic       pressure_start = 1'b0;
  logic [VALUE_W-1:0] value_pool[8];

  // local copy of the ring store
  logic [VALUE_W-1:0] deque_mem[DEPTH];
  int                 deque_front = 0;
  logic [COUNT_W-1:0] deque_count = '0;

  bounded_deque_with_search #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic result_t deque_apply(input logic [CMD_W-1:0] cmd,
                                          input logic [VALUE_W-1:0] value);
    result_t res;
    int      i;
    res.status = STS_OK;
    res.found  = 1'b0;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (deque_count >= DEPTH) begin
          res.status = STS_FULL;
        end else begin
          if (cmd == CMD_PUSH_FRONT) begin
            deque_front = (deque_front + DEPTH - 1) % DEPTH;
            deque_mem[deque_front] = value;
          end else begin
            deque_mem[(deque_front + deque_count) % DEPTH] = value;
          end
          deque_count = deque_count + 1'b1;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (deque_count == 0) begin
          res.status = STS_EMPTY;
        end else begin
          if (cmd == CMD_POP_FRONT) deque_front = (deque_front + 1) % DEPTH;
          deque_count = deque_count - 1'b1;
        end
      end
      CMD_CLEAR: begin
        if (deque_count == 0) begin
          res.status = STS_EMPTY;
        end else begin
          deque_count = '0;
          deque_front = 0;
        end
      end
      CMD_SEARCH: begin
        if (deque_count == 0) begin
          res.status = STS_EMPTY;
        end else begin
          for (i = 0; i < deque_count; i++) begin
            if (deque_mem[(deque_front + i) % DEPTH] == value) res.found = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    res.count = deque_count;
    return res;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return value_pool[$urandom_range(0, 7)];
    if (sel < 8) return $urandom();
    if (sel == 8) begin
      case ($urandom_range(0, 3))
        0: return 32'h7fff_ffff;
        1: return 32'h8000_0000;
        2: return 32'hffff_ffff;
        default: return 32'h0;
      endcase
    end
    return $urandom_range(0, 3);
  endfunction

  task automatic add_req(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value);
    deque_req_t req;
    req.cmd   = cmd;
    req.value = value;
    request_queue.push_back(req);
  endtask

  // half of the bursts are runs that fill or drain the store so that full and empty are reached
  task automatic add_burst(output int added);
    int               kind;
    int               n;
    int               i;
    logic [CMD_W-1:0] cmd;
    value_pool[$urandom_range(0, 7)] = $urandom();
    kind  = $urandom_range(0, 9);
    added = 0;
    if (kind <= 2) begin
      n = $urandom_range(14, 22);
      for (i = 0; i < n; i++) begin
        cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        if ($urandom_range(0, 3) == 0) cmd = CMD_SEARCH;
        add_req(cmd, pick_value());
      end
    end else if (kind <= 4) begin
      n = $urandom_range(10, 22);
      for (i = 0; i < n; i++) begin
        cmd = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
        if ($urandom_range(0, 4) == 0) cmd = CMD_SEARCH;
        add_req(cmd, pick_value());
      end
    end else if (kind <= 7) begin
      n = 10;
      for (i = 0; i < n; i++) add_req(CMD_W'($urandom_range(0, 7)), pick_value());
    end else if (kind == 8) begin
      n = 4;
      add_req(CMD_CLEAR, $urandom());
      for (i = 1; i < n; i++) add_req(CMD_W'($urandom_range(0, 7)), pick_value());
    end else begin
      n = 6;
      for (i = 0; i < n; i++) add_req(CMD_SEARCH, pick_value());
    end
    added = n;
  endtask

  task automatic wait_drained();
    while (request_queue.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // request driver
  always @(negedge clk) begin
    deque_req_t req;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (request_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        req = request_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= req.value;
        in_tuser  <= req.cmd;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= rst_n && !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // long receiver hold so the input side backs up
  initial begin : long_hold
    wait (pressure_start);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    hold_off = 1'b0;
  end

  // result checker, compares before recording the request of this edge
  always @(posedge clk) begin
    result_t got;
    result_t want;
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result status %0d found %0d count %0d",
                   $time, got.status, got.found, got.count);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch, expected status %0d found %0d count %0d, got %0d %0d %0d",
                     $time, want.status, want.found, want.count,
                     got.status, got.found, got.count);
            mismatch_count++;
          end
        end
      end
      if (in_tvalid && in_tready) expected_results.push_back(deque_apply(in_tuser, in_tdata));
    end
  end

  initial begin : stimulus
    int p;
    int total;
    int added;
    value_pool[0] = 32'h7fff_ffff;
    value_pool[1] = 32'h8000_0000;
    value_pool[2] = 32'hffff_ffff;
    value_pool[3] = 32'h0;
    for (p = 4; p < 8; p++) value_pool[p] = $urandom();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty store first, then both ends, search hits and misses, last-entry pops
    add_req(CMD_SEARCH, 32'h0);
    add_req(CMD_POP_FRONT, 32'h0);
    add_req(CMD_POP_BACK, 32'h0);
    add_req(CMD_CLEAR, 32'h0);
    add_req(CMD_UNUSED_6, 32'hffff_ffff);
    add_req(CMD_UNUSED_7, 32'h0);
    add_req(CMD_PUSH_FRONT, 32'h7fff_ffff);
    add_req(CMD_PUSH_BACK, 32'h8000_0000);
    add_req(CMD_PUSH_FRONT, 32'hffff_ffff);
    add_req(CMD_PUSH_BACK, 32'h0);
    add_req(CMD_SEARCH, 32'h8000_0000);
    add_req(CMD_SEARCH, 32'h7fff_ffff);
    add_req(CMD_SEARCH, 32'h1);
    add_req(CMD_SEARCH, 32'h0);
    add_req(CMD_POP_FRONT, 32'h0);
    add_req(CMD_POP_BACK, 32'h0);
    add_req(CMD_CLEAR, 32'h0);
    add_req(CMD_PUSH_BACK, 32'h5);
    add_req(CMD_POP_FRONT, 32'h0);
    add_req(CMD_PUSH_FRONT, 32'h1234_5678);
    add_req(CMD_POP_BACK, 32'h0);
    add_req(CMD_SEARCH, 32'h1234_5678);
    wait_drained();

    pressure_start = 1'b1;
    wait (hold_off);
    for (p = 0; p < 24; p++) add_req($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_SEARCH,
                                     pick_value());
    wait_drained();

    for (p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 77;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 77;
        end
        default: begin
          send_idle_pct  = 15;
          recv_stall_pct = 15;
        end
      endcase
      total = 0;
      while (total < PHASE_REQS) begin
        add_burst(added);
        total += added;
      end
      wait_drained();
    end

    // a search is the slowest request, leave room for a stray result
    repeat (4 * DEPTH) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
sv/bdqs_pkg.sv
sv/bdqs_ram.sv
sv/bdqs_front.sv
sv/bdqs_back.sv
sv/bounded_deque_with_search.sv
bench/bounded_deque_with_search_tb.sv
